[design/awu_pkg.sv]
// Adam weight update: shared types, constants and saturation helper.
// No dependencies; imported by every module of the block.
`default_nettype none
package awu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int NUM_W         = 64;   // step_rate * |mean|
    localparam int DEN_W         = 33;   // sqrt(var) + epsilon
    localparam int QUO_W         = 35;   // step magnitude, clamps at 2^34
    localparam int STEP_W        = 37;   // signed weight update sum

    localparam logic [16:0]      BETA_ONE = 17'h10000;
    localparam logic [QUO_W-1:0] STEP_MAX = 35'h4_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_RATE    = 3'd0,
        CFG_DECAY_FACTOR = 3'd1,
        CFG_GRAD_SCALE   = 3'd2,
        CFG_GRAD_CEILING = 3'd3,
        CFG_FIRST_DECAY  = 3'd4,
        CFG_SECOND_DECAY = 3'd5,
        CFG_DENOM_BIAS   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] weight_in;
        logic signed [31:0] grad_in;
        logic signed [31:0] mean_in;
        logic        [31:0] var_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] weight_out;
        logic signed [31:0] mean_out;
        logic        [31:0] var_out;
    } t_out_item;

    typedef struct packed {
        logic        [31:0] step_rate;
        logic signed [31:0] decay_factor;
        logic signed [31:0] grad_scale;
        logic signed [31:0] grad_ceiling;
        logic        [15:0] first_decay;
        logic        [15:0] second_decay;
        logic        [31:0] denom_bias;
    } t_cfg;

    // values that ride alongside the root pipeline
    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] mean;
        logic        [31:0] var_n;
        logic   [NUM_W-1:0] num;
    } t_carry;

    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] mean;
        logic        [31:0] var_n;
        logic               zero;   // numerator is zero
        logic               ovf;    // quotient at or above 2^QUO_W
    } t_tail;

    function automatic logic signed [31:0] sat_s32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = signed'(x[31:0]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/adam_weight_update_unit.sv]
// Adam weight update (no bias correction), fully pipelined top level.
// Depends on awu_pkg, awu_front, awu_sqrt and awu_div.
`default_nettype none
// Usage
//   Input: one element (weight, gradient, first and second moment) per
//   transfer, taken on every edge where start is high; busy stays low,
//   so a new element may enter every cycle.
//   Output: o_valid pulses for one cycle with the updated weight, mean and
//   variance in o_result. Results come out in input order.
//   Pipeline: gradient/moment front, root (R = (32+FRAC_BITS+1)/2 bits),
//   denominator, rounded dividend, 35-bit divider and output register.
//   Throughput one element per cycle, set by the per-bit stages of the
//   root and divider pipelines.
//   Config: i_cfg_valid/o_cfg_ready write channel, always ready; index 0..6
//   selects the register, other indexes are dropped. Write only while no
//   element is in flight; the pipeline reads the registers live.
//   Reset: synchronous, active low; clears the valid chain and loads the
//   register defaults. Data registers are not reset.
//   The receiver cannot stall; no backpressure path exists.
module adam_weight_update_unit #(
    parameter int FRAC_BITS = awu_pkg::FRAC_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  awu_pkg::t_in_item              i_item,
    output logic                           o_valid,
    output awu_pkg::t_out_item             o_result,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [awu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [31:0]                    i_cfg_data
);
    import awu_pkg::*;

    localparam int SQ_IN_W = 32 + FRAC_BITS;
    localparam int R       = (SQ_IN_W + 1) / 2;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_rate    <= 32'd66;
            r_cfg.decay_factor <= 32'sd0;
            r_cfg.grad_scale   <= 32'sd65536;
            r_cfg.grad_ceiling <= -32'sd65536;
            r_cfg.first_decay  <= 16'd58982;
            r_cfg.second_decay <= 16'd65470;
            r_cfg.denom_bias   <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_RATE:    r_cfg.step_rate    <= i_cfg_data;
                CFG_DECAY_FACTOR: r_cfg.decay_factor <= signed'(i_cfg_data);
                CFG_GRAD_SCALE:   r_cfg.grad_scale   <= signed'(i_cfg_data);
                CFG_GRAD_CEILING: r_cfg.grad_ceiling <= signed'(i_cfg_data);
                CFG_FIRST_DECAY:  r_cfg.first_decay  <= i_cfg_data[15:0];
                CFG_SECOND_DECAY: r_cfg.second_decay <= i_cfg_data[15:0];
                CFG_DENOM_BIAS:   r_cfg.denom_bias   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // every cycle is open for a transfer on both channels
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // front: conditioned gradient, new moments, step numerator
    logic   f_valid;
    t_carry f_carry;

    awu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_carry (f_carry)
    );

    // root of the new variance, scaled back into the fixed-point format
    logic         s_valid;
    logic [R-1:0] s_root;
    t_carry       s_carry;

    awu_sqrt #(.IN_W(SQ_IN_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_x     ({f_carry.var_n, FRAC_BITS'(0)}),
        .i_carry (f_carry),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_carry (s_carry)
    );

    // denominator stage
    logic             r_d_v;
    logic [DEN_W-1:0] r_d_den;
    t_carry           r_d_c;

    // rounded dividend stage, with quotient overflow and zero flags
    logic             r_e_v;
    logic [NUM_W-1:0] r_e_dvd;
    logic [DEN_W-1:0] r_e_den;
    t_tail            r_e_t;
    logic [NUM_W-1:0] n_e_dvd;

    assign n_e_dvd = r_d_c.num + NUM_W'(r_d_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            r_d_v <= s_valid;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_den      <= DEN_W'(s_root) + DEN_W'(r_cfg.denom_bias);
        r_d_c        <= s_carry;
        r_e_dvd      <= n_e_dvd;
        r_e_den      <= r_d_den;
        r_e_t.weight <= r_d_c.weight;
        r_e_t.mean   <= r_d_c.mean;
        r_e_t.var_n  <= r_d_c.var_n;
        r_e_t.zero   <= (r_d_c.num == '0);
        // a zero denominator lands here too and clamps the step
        r_e_t.ovf    <= (DEN_W'(n_e_dvd[NUM_W-1:QUO_W]) >= r_d_den);
    end

    logic             q_valid;
    logic [QUO_W-1:0] q_quo;
    t_tail            q_tail;

    awu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_e_v),
        .i_dividend (r_e_dvd),
        .i_den      (r_e_den),
        .i_tail     (r_e_t),
        .o_valid    (q_valid),
        .o_quo      (q_quo),
        .o_tail     (q_tail)
    );

    // step clamp, sign and weight update
    logic        [QUO_W-1:0]  n_step;
    logic signed [STEP_W-1:0] n_wsum;

    always_comb begin
        if (q_tail.zero) begin
            n_step = '0;
        end else if (q_tail.ovf || q_quo > STEP_MAX) begin
            n_step = STEP_MAX;
        end else begin
            n_step = q_quo;
        end
        if (q_tail.mean < 0) begin
            n_wsum = STEP_W'(q_tail.weight) + signed'(STEP_W'(n_step));
        end else begin
            n_wsum = STEP_W'(q_tail.weight) - signed'(STEP_W'(n_step));
        end
    end

    logic      r_o_v;
    t_out_item r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o.weight_out <= sat_s32(66'(n_wsum));
        r_o.mean_out   <= q_tail.mean;
        r_o.var_out    <= q_tail.var_n;
    end

    assign o_valid  = r_o_v;
    assign o_result = r_o;

endmodule
`default_nettype wire

[design/awu_front.sv]
// Adam weight update: gradient conditioning, moment updates and step numerator.
// Seven register stages; depends on awu_pkg.
`default_nettype none
module awu_front #(
    parameter int FRAC_BITS = awu_pkg::FRAC_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  awu_pkg::t_in_item i_item,
    input  awu_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output awu_pkg::t_carry  o_carry
);
    import awu_pkg::*;

    localparam logic signed [63:0] HALF_S = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic        [64:0] HALF_U = 65'd1 << (FRAC_BITS - 1);
    localparam logic        [47:0] SQ_MAX = 48'hFFFF_FFFF_FFFF;

    logic [7:1] r_v;

    // stage 1: gradient scale and weight decay products
    logic signed [31:0] r1_w, r1_m;
    logic        [31:0] r1_var;
    logic signed [63:0] r1_pg, r1_pw;
    // stage 2: scaled, clipped gradient and rounded decay term
    logic signed [31:0] r2_w, r2_m, r2_gc;
    logic        [31:0] r2_var;
    logic signed [63:0] r2_wd;
    // stage 3: conditioned gradient
    logic signed [31:0] r3_w, r3_m, r3_g;
    logic        [31:0] r3_var;
    // stage 4: moment products
    logic signed [31:0] r4_w;
    logic        [31:0] r4_var;
    logic signed [49:0] r4_pm1, r4_pm2;
    logic        [63:0] r4_gsq;
    // stage 5: new mean, rounded square
    logic signed [31:0] r5_w, r5_mn;
    logic        [31:0] r5_var;
    logic        [47:0] r5_sq;
    // stage 6: variance products, step numerator
    logic signed [31:0] r6_w, r6_mn;
    logic        [47:0] r6_pv;
    logic        [64:0] r6_ps;
    logic        [63:0] r6_num;
    // stage 7
    t_carry r7_c;

    logic signed [63:0] n2_gs_full;
    logic signed [31:0] n2_gs, n2_gc, ceil_s;
    logic        [31:0] n4_gmag, n6_mmag;
    logic signed [49:0] n5_msum;
    logic        [64:0] n5_sq_full;
    logic        [47:0] n5_sq;
    logic        [65:0] n7_vacc;
    logic        [31:0] n7_vn;

    always_comb begin
        ceil_s     = i_cfg.grad_ceiling;
        n2_gs_full = (r1_pg + HALF_S) >>> FRAC_BITS;
        n2_gs      = sat_s32(66'(n2_gs_full));
        n2_gc      = (ceil_s >= 0 && n2_gs > ceil_s) ? ceil_s : n2_gs;
        n4_gmag    = (r3_g < 0) ? 32'(-r3_g) : 32'(r3_g);
        n5_msum    = (r4_pm1 + r4_pm2 + 50'sd32768) >>> 16;
        n5_sq_full = ({1'b0, r4_gsq} + HALF_U) >> FRAC_BITS;
        n5_sq      = (n5_sq_full > 65'(SQ_MAX)) ? SQ_MAX : n5_sq_full[47:0];
        n6_mmag    = (r5_mn < 0) ? 32'(-r5_mn) : 32'(r5_mn);
        n7_vacc    = 66'(r6_pv) + 66'(r6_ps) + 66'd32768;
        n7_vn      = (n7_vacc[65:16] > 50'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : n7_vacc[47:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_w   <= i_item.weight_in;
        r1_m   <= i_item.mean_in;
        r1_var <= i_item.var_in;
        r1_pg  <= $signed(i_item.grad_in) * $signed(i_cfg.grad_scale);
        r1_pw  <= $signed(i_cfg.decay_factor) * $signed(i_item.weight_in);

        r2_w   <= r1_w;
        r2_m   <= r1_m;
        r2_var <= r1_var;
        r2_gc  <= n2_gc;
        r2_wd  <= (r1_pw + HALF_S) >>> FRAC_BITS;

        r3_w   <= r2_w;
        r3_m   <= r2_m;
        r3_var <= r2_var;
        r3_g   <= sat_s32(66'(r2_gc) + 66'(r2_wd));

        r4_w   <= r3_w;
        r4_var <= r3_var;
        r4_pm1 <= $signed({1'b0, i_cfg.first_decay}) * r3_m;
        // 1 - beta1 reaches 1.0 (bit 16), so keep a zero sign bit above it
        r4_pm2 <= $signed({1'b0, BETA_ONE - {1'b0, i_cfg.first_decay}}) * r3_g;
        r4_gsq <= 64'(n4_gmag) * 64'(n4_gmag);

        r5_w   <= r4_w;
        r5_var <= r4_var;
        r5_mn  <= sat_s32(66'(n5_msum));
        r5_sq  <= n5_sq;

        r6_w   <= r5_w;
        r6_mn  <= r5_mn;
        r6_pv  <= 48'(i_cfg.second_decay) * 48'(r5_var);
        r6_ps  <= 65'(BETA_ONE - {1'b0, i_cfg.second_decay}) * 65'(r5_sq);
        r6_num <= 64'(n6_mmag) * 64'(i_cfg.step_rate);

        r7_c.weight <= r6_w;
        r7_c.mean   <= r6_mn;
        r7_c.var_n  <= n7_vn;
        r7_c.num    <= r6_num;
    end

    assign o_valid = r_v[7];
    assign o_carry = r7_c;

endmodule
`default_nettype wire

[design/awu_sqrt.sv]
// Adam weight update: pipelined floor square root, one root bit per stage.
// Depends on awu_pkg for the side-band carry type.
`default_nettype none
module awu_sqrt #(
    parameter int IN_W = 48
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire  [IN_W-1:0]          i_x,
    input  awu_pkg::t_carry          i_carry,
    output logic                     o_valid,
    output logic [(IN_W+1)/2-1:0]    o_root,
    output awu_pkg::t_carry          o_carry
);
    import awu_pkg::*;

    localparam int R   = (IN_W + 1) / 2;
    localparam int X_W = 2 * R;
    localparam int RW  = R + 3;

    logic [R:0]     r_v;
    logic [X_W-1:0] r_x    [0:R];
    logic [RW-1:0]  r_rem  [0:R];
    logic [R-1:0]   r_root [0:R];
    t_carry         r_c    [0:R];

    logic [RW-1:0]  n_rem  [0:R-1];
    logic [R-1:0]   n_root [0:R-1];

    always_comb begin
        for (int i = 0; i < R; i++) begin
            logic [RW-1:0] t, trial;
            t         = {r_rem[i][RW-3:0], r_x[i][X_W-1 -: 2]};
            trial     = RW'({r_root[i], 2'b01});
            n_rem[i]  = (t >= trial) ? t - trial : t;
            n_root[i] = {r_root[i][R-2:0], (t >= trial)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[R-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= X_W'(i_x);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_c[0]    <= i_carry;
        for (int i = 0; i < R; i++) begin
            r_x[i+1]    <= r_x[i] << 2;
            r_rem[i+1]  <= n_rem[i];
            r_root[i+1] <= n_root[i];
            r_c[i+1]    <= r_c[i];
        end
    end

    assign o_valid = r_v[R];
    assign o_root  = r_root[R];
    assign o_carry = r_c[R];

endmodule
`default_nettype wire

[design/awu_div.sv]
// Adam weight update: pipelined restoring divider, one quotient bit per stage.
// Depends on awu_pkg for widths and the side-band tail type.
`default_nettype none
module awu_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire  [awu_pkg::NUM_W-1:0]  i_dividend,
    input  wire  [awu_pkg::DEN_W-1:0]  i_den,
    input  awu_pkg::t_tail             i_tail,
    output logic                       o_valid,
    output logic [awu_pkg::QUO_W-1:0]  o_quo,
    output awu_pkg::t_tail             o_tail
);
    import awu_pkg::*;

    localparam int Q = QUO_W;

    logic [Q:0]       r_v;
    logic [Q-1:0]     r_lo  [0:Q];
    logic [DEN_W-1:0] r_rem [0:Q];
    logic [DEN_W-1:0] r_den [0:Q];
    logic [Q-1:0]     r_quo [0:Q];
    t_tail            r_t   [0:Q];

    logic [DEN_W-1:0] n_rem [0:Q-1];
    logic             n_ge  [0:Q-1];

    always_comb begin
        for (int i = 0; i < Q; i++) begin
            logic [DEN_W:0] t, d;
            t        = {r_rem[i], r_lo[i][Q-1]};
            d        = {1'b0, r_den[i]};
            n_ge[i]  = (t >= d);
            n_rem[i] = n_ge[i] ? DEN_W'(t - d) : DEN_W'(t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[Q-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo[0]  <= i_dividend[Q-1:0];
        r_rem[0] <= DEN_W'(i_dividend[NUM_W-1:Q]);
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_t[0]   <= i_tail;
        for (int i = 0; i < Q; i++) begin
            r_lo[i+1]  <= r_lo[i] << 1;
            r_rem[i+1] <= n_rem[i];
            r_den[i+1] <= r_den[i];
            r_quo[i+1] <= {r_quo[i][Q-2:0], n_ge[i]};
            r_t[i+1]   <= r_t[i];
        end
    end

    assign o_valid = r_v[Q];
    assign o_quo   = r_quo[Q];
    assign o_tail  = r_t[Q];

endmodule
`default_nettype wire

[verif/tb_adam_weight_update_unit.sv]
// Self-checking testbench for adam_weight_update_unit: directed and random elements
// under several register settings, checked against an in-bench Adam predictor.
// Depends on awu_pkg and the adam_weight_update_unit RTL.
`default_nettype none

class adam_scoreboard;
    awu_pkg::t_cfg       regs;
    awu_pkg::t_out_item  pending[$];
    int                  mismatches;
    int                  checked;

    function new();
        mismatches = 0;
        checked = 0;
        load_defaults();
    endfunction

    function void load_defaults();
        regs.step_rate    = 32'd66;
        regs.decay_factor = 32'sd0;
        regs.grad_scale   = 32'sd65536;
        regs.grad_ceiling = 32'hFFFF_0000;
        regs.first_decay  = 16'd58982;
        regs.second_decay = 16'd65470;
        regs.denom_bias   = 32'd1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            awu_pkg::CFG_STEP_RATE:    regs.step_rate    = d;
            awu_pkg::CFG_DECAY_FACTOR: regs.decay_factor = d;
            awu_pkg::CFG_GRAD_SCALE:   regs.grad_scale   = d;
            awu_pkg::CFG_GRAD_CEILING: regs.grad_ceiling = d;
            awu_pkg::CFG_FIRST_DECAY:  regs.first_decay  = d[15:0];
            awu_pkg::CFG_SECOND_DECAY: regs.second_decay = d[15:0];
            awu_pkg::CFG_DENOM_BIAS:   regs.denom_bias   = d;
            default: ;
        endcase
    endfunction

    // product rescale: round to nearest, ties toward +inf
    function longint rnd_shr(longint a);
        return (a + 64'sd32768) >>> 16;
    endfunction

    function longint clip32(longint a);
        if (a > 64'sd2147483647) return 64'sd2147483647;
        if (a < -64'sd2147483648) return -64'sd2147483648;
        return a;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function awu_pkg::t_out_item adam_update(awu_pkg::t_in_item x);
        awu_pkg::t_out_item r;
        longint w, g, m, ceil_v, scale, decay, b1, mn, step, wn;
        longint unsigned v, b2, gmag, sq, vacc, vn, den, mmag, rate, num, stepmag;
        w = longint'($signed(x.weight_in));
        g = longint'($signed(x.grad_in));
        m = longint'($signed(x.mean_in));
        v = longint'(x.var_in);
        ceil_v = longint'($signed(regs.grad_ceiling));
        scale = longint'($signed(regs.grad_scale));
        decay = longint'($signed(regs.decay_factor));
        b1 = longint'(regs.first_decay);
        b2 = regs.second_decay;
        rate = regs.step_rate;

        // gradient: scale, optional upper clip, weight decay
        g = clip32(rnd_shr(g * scale));
        if (ceil_v >= 0 && g > ceil_v) g = ceil_v;
        g = clip32(g + rnd_shr(decay * w));

        mn = clip32(rnd_shr(b1 * m + (64'sd65536 - b1) * g));

        gmag = (g < 0) ? -g : g;
        sq = (gmag * gmag + 64'd32768) >> 16;
        if (sq > 64'hFFFF_FFFF_FFFF) sq = 64'hFFFF_FFFF_FFFF;
        vacc = b2 * v + (64'd65536 - b2) * sq + 64'd32768;
        vn = vacc >> 16;
        if (vn > 64'hFFFF_FFFF) vn = 64'hFFFF_FFFF;

        den = int_sqrt(vn << 16) + longint'(regs.denom_bias);
        mmag = (mn < 0) ? -mn : mn;
        num = mmag * rate;
        if (num == 0) stepmag = 0;
        else if (den == 0) stepmag = 64'd1 << 34;   // zero denominator saturates
        else stepmag = (num + (den >> 1)) / den;
        if (stepmag > (64'd1 << 34)) stepmag = 64'd1 << 34;
        step = stepmag;
        if (mn < 0) step = -step;
        wn = clip32(w - step);

        r.weight_out = wn[31:0];
        r.mean_out   = mn[31:0];
        r.var_out    = vn[31:0];
        return r;
    endfunction

    function void note_input(awu_pkg::t_in_item x);
        pending.push_back(adam_update(x));
    endfunction

    function void check_result(awu_pkg::t_out_item got);
        awu_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result w=%h m=%h v=%h",
                         got.weight_out, got.mean_out, got.var_out);
            return;
        end
        exp_r = pending.pop_front();
        checked++;
        if (got.weight_out !== exp_r.weight_out || got.mean_out !== exp_r.mean_out ||
            got.var_out !== exp_r.var_out) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d exp w=%h m=%h v=%h got w=%h m=%h v=%h",
                         checked, exp_r.weight_out, exp_r.mean_out, exp_r.var_out,
                         got.weight_out, got.mean_out, got.var_out);
        end
    endfunction
endclass

module tb_adam_weight_update_unit;
    import awu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;  // no register here
    localparam int DRAIN_CYCLES = 100;      // pipeline is 71 deep
    localparam int CYCLE_LIMIT  = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    t_in_item     i_item;
    logic         o_valid;
    t_out_item    o_result;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]  i_cfg_data;

    adam_scoreboard sb;
    int accepted_items;
    int cfg_transfers;
    int cycles;
    int phases_run;

    adam_weight_update_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // monitor: every transfer is sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_input(i_item);
                accepted_items++;
            end
            if (o_valid) sb.check_result(o_result);
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                cfg_transfers++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, sb.pending.size());
            $display("adam_weight_update_unit test failed");
            $finish;
        end
    end

    // all tasks are entered and left at a falling edge
    task automatic push_element(t_in_item x);
        int n0;
        n0 = accepted_items;
        start <= 1'b1;
        i_item <= x;
        do @(negedge i_clk); while (accepted_items == n0);
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        int n0;
        n0 = cfg_transfers;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(negedge i_clk); while (cfg_transfers == n0);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_setting(t_cfg c);
        drain();
        write_cfg(CFG_STEP_RATE, c.step_rate);
        write_cfg(CFG_DECAY_FACTOR, c.decay_factor);
        write_cfg(CFG_GRAD_SCALE, c.grad_scale);
        write_cfg(CFG_GRAD_CEILING, c.grad_ceiling);
        write_cfg(CFG_FIRST_DECAY, {16'd0, c.first_decay});
        write_cfg(CFG_SECOND_DECAY, {16'd0, c.second_decay});
        write_cfg(CFG_DENOM_BIAS, c.denom_bias);
        phases_run++;
    endtask

    function automatic logic [31:0] pick_word(logic sgn);
        case ($urandom_range(0, 7))
            0, 1: pick_word = $urandom;
            2: pick_word = sgn ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                               : ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            default: begin
                pick_word = $urandom_range(0, 32'h0004_0000);
                if (sgn && $urandom_range(0, 1)) pick_word = -pick_word;
            end
        endcase
    endfunction

    function automatic t_in_item rand_element();
        t_in_item x;
        x.weight_in = pick_word(1'b1);
        x.grad_in   = pick_word(1'b1);
        x.mean_in   = pick_word(1'b1);
        x.var_in    = pick_word(1'b0);
        return x;
    endfunction

    function automatic t_cfg rand_setting();
        t_cfg c;
        c.step_rate    = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000);
        c.decay_factor = $urandom_range(0, 3) == 0 ? $urandom
                                                    : $urandom_range(0, 32'h2000) - 32'h1000;
        c.grad_scale   = $urandom_range(0, 3) == 0 ? $urandom
                                                    : $urandom_range(0, 32'h4_0000) - 32'h2_0000;
        c.grad_ceiling = $urandom_range(0, 1) ? $urandom_range(0, 32'h4_0000) : $urandom;
        c.first_decay  = $urandom;
        c.second_decay = $urandom;
        c.denom_bias   = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64);
        return c;
    endfunction

    // random bursts separated by random gaps, some bursts gap-free
    task automatic random_traffic(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < count; k++) begin
                push_element(rand_element());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 12));
        end
    endtask

    initial begin
        t_cfg      c;
        t_in_item  x;
        sb = new();
        accepted_items = 0;
        cfg_transfers = 0;
        cycles = 0;
        phases_run = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset setting: field extremes
        push_element('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF});
        push_element('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'h0});
        push_element('{32'sh0001_0000, 32'sh0, 32'sh0, 32'h0});
        push_element('{32'sh0, 32'shFFFF_0000, 32'sh0001_0000, 32'h0001_0000});
        push_element('{32'shFFFF_FFFF, 32'sh0000_8000, 32'shFFFF_FFFF, 32'h0000_0001});

        // upper clip active, strong decay, ceiling at zero
        c = sb.regs;
        c.grad_ceiling = 32'sh0;
        c.decay_factor = 32'sh0001_0000;
        load_setting(c);
        write_cfg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);   // dropped by the block
        push_element('{32'sh0002_0000, 32'sh0003_0000, 32'sh0, 32'h0});
        push_element('{32'shFFFE_0000, 32'sh0003_0000, 32'sh0, 32'h0});
        push_element('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'h0});

        // zero epsilon: zero denominator with nonzero and zero numerator
        c.grad_ceiling = 32'shFFFF_FFFF;
        c.decay_factor = 32'sh0;
        c.denom_bias   = 32'd0;
        c.first_decay  = 16'hFFFF;
        c.second_decay = 16'hFFFF;
        load_setting(c);
        push_element('{32'sh0, 32'sh0, 32'sh0100_0000, 32'h0});
        push_element('{32'sh0, 32'sh0, 32'shFF00_0000, 32'h0});
        push_element('{32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF, 32'h0});
        push_element('{32'sh1234_0000, 32'sh0, 32'sh0, 32'h0});

        // register extremes
        c = '{32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              16'h0, 16'h0, 32'hFFFF_FFFF};
        load_setting(c);
        push_element('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF});
        push_element('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0});
        random_traffic(40);
        c = '{32'h0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              16'hFFFF, 16'h0, 32'h0};
        load_setting(c);
        push_element('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF});
        random_traffic(40);

        // random settings, random traffic
        for (int p = 0; p < 8; p++) begin
            load_setting(rand_setting());
            random_traffic(120);
            drain();                 // sender waits for all results mid-phase
            random_traffic(120);
        end
        sb.load_defaults();
        drain();
        c = sb.regs;
        load_setting(c);
        random_traffic(40);

        drain();
        $display("covered %0d elements over %0d register settings, %0d results checked",
                 accepted_items, phases_run, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("adam_weight_update_unit test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("adam_weight_update_unit test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
